// ----- src/devc_pkg.sv -----
// Shared types and constants for the decimal exponent varint codec.
// Used by devc_hundred_slot and decimal_exponent_varint_codec_top; no dependencies.
package devc_pkg;

   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   localparam int VALUE_BITS     = 64;
   localparam int HUNDREDS_BITS  = 3;
   localparam int LENGTH_BITS    = 6;
   localparam int TOTAL_BITS     = 7;
   localparam int HUNDREDS_SLOTS = (1 << HUNDREDS_BITS) - 1;

   localparam logic [TOTAL_BITS-1:0] HUNDREDS_HEAD = 7'd3;
   localparam logic [TOTAL_BITS-1:0] LENGTH_HEAD   = 7'd6;

   // inverse of 25 modulo 2^64, split in halves, and the largest quotient of an exact division
   localparam logic [31:0] INV25_LO = 32'hC28F_5C29;
   localparam logic [31:0] INV25_HI = 32'h8F5C_28F5;
   localparam logic [63:0] DIV25_MAX = 64'h0A3D_70A3_D70A_3D70;
   localparam logic [70:0] HUNDRED   = 71'd100;

   typedef struct packed {
      logic                     action;
      logic                     with_hundreds;
      logic [VALUE_BITS-1:0]    val;
      logic [HUNDREDS_BITS-1:0] hundreds;
      logic [LENGTH_BITS-1:0]   length;
      logic                     ovf;
   } item_type;

endpackage

// ----- src/devc_hundred_slot.sv -----
// One factor-of-100 slot: strips a factor of 100 when encoding, applies one when decoding.
// Two register stages with valid bits; depends on devc_pkg.
module devc_hundred_slot #(
   parameter int SLOT         = 0,
   parameter int MAX_HUNDREDS = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  devc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output devc_pkg::item_type out_item
);

   localparam logic STRIP_EN = (SLOT < MAX_HUNDREDS);

   logic               a_valid_ff;
   devc_pkg::item_type a_item_ff;
   logic [63:0]        a_p0_ff;
   logic [31:0]        a_pc_ff;
   logic               a_div4_ff;
   logic [70:0]        a_prod_ff;

   logic               b_valid_ff;
   devc_pkg::item_type b_item_ff;
   devc_pkg::item_type b_item_in;

   logic        a_ready;
   logic        b_ready;
   logic [31:0] a_lo;
   logic [29:0] a_hi;
   logic [63:0] p0_in;
   logic [31:0] pc_a;
   logic [31:0] pc_b;
   logic [70:0] prod_in;
   logic [63:0] quot;
   logic        strip;
   logic        mult;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_lo    = in_item.val[33:2];
   assign a_hi    = in_item.val[63:34];
   assign p0_in   = {32'b0, a_lo} * {32'b0, devc_pkg::INV25_LO};
   assign pc_a    = a_lo * devc_pkg::INV25_HI;
   assign pc_b    = {2'b0, a_hi} * devc_pkg::INV25_LO;
   assign prod_in = {7'b0, in_item.val} * devc_pkg::HUNDRED;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_item_ff <= in_item;
         a_p0_ff   <= p0_in;
         a_pc_ff   <= pc_a + pc_b;
         a_div4_ff <= (in_item.val[1:0] == 2'b00);
         a_prod_ff <= prod_in;
      end
      if (b_ready) b_item_ff <= b_item_in;
   end

   assign quot  = a_p0_ff + {a_pc_ff, 32'b0};
   assign strip = (a_item_ff.action == devc_pkg::ACT_ENCODE) && a_item_ff.with_hundreds
                  && STRIP_EN && a_div4_ff && (quot <= devc_pkg::DIV25_MAX);
   assign mult  = (a_item_ff.action == devc_pkg::ACT_DECODE) && !a_item_ff.ovf
                  && (3'(SLOT) < a_item_ff.hundreds);

   always_comb begin
      b_item_in = a_item_ff;
      if (strip) begin
         b_item_in.val      = quot;
         b_item_in.hundreds = a_item_ff.hundreds + 3'd1;
      end else if (mult) begin
         if (a_prod_ff[70:64] != 7'd0) b_item_in.ovf = 1'b1;
         else b_item_in.val = a_prod_ff[63:0];
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ----- src/decimal_exponent_varint_codec_top.sv -----
// Top level of the decimal exponent varint codec: input register, factor-of-100 slots,
// bit-length stages and output register. Depends on devc_pkg and devc_hundred_slot.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: number, hundreds_in, length_in
//                                               tuser: action, with_hundreds
//   rsp      out        rsp_tvalid/rsp_tready  tdata: result_number, hundreds_out,
//                                               length_out, total_bits; tuser: overflow
//
// One item per cycle sustained while rsp_tready stays high; stages: input register, two stages per
// factor-of-100 slot (seven slots, the multiply and the reduce stage), three length stages.
// Reset clears the valid bits only; no clearing pass.
// Each stage holds its item while the next one is full and stalled, so bubbles close up and
// the input is taken while a result waits at the output.
module decimal_exponent_varint_codec_top #(
   parameter int MAX_HUNDREDS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // number[63:0], hundreds_in[66:64], length_in[72:67], zero
   input  logic [1:0]  req_tuser,  // action[0], with_hundreds[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // result_number[63:0], hundreds_out[66:64],
                                   // length_out[72:67], total_bits[79:73]
   output logic        rsp_tuser   // overflow
);

   localparam int SLOTS = devc_pkg::HUNDREDS_SLOTS;

   logic               s0_valid_ff;
   devc_pkg::item_type s0_item_ff;
   devc_pkg::item_type s0_item_in;

   logic               chain_valid [SLOTS+1];
   logic               chain_ready [SLOTS+1];
   devc_pkg::item_type chain_item  [SLOTS+1];

   logic               l1_valid_ff;
   devc_pkg::item_type l1_item_ff;
   logic [63:0]        l1_dec_ff;
   logic               l1_small_ff;

   logic               l2_valid_ff;
   devc_pkg::item_type l2_item_ff;
   logic               l2_small_ff;
   logic [7:0]         l2_bnz_ff;
   logic [7:0][2:0]    l2_bpos_ff;
   logic [7:0]         l2_bnz_in;
   logic [7:0][2:0]    l2_bpos_in;

   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;
   logic        rsp_ovf_ff;
   logic [79:0] rsp_data_in;

   logic        s0_ready;
   logic        l1_ready;
   logic        l2_ready;
   logic        l3_ready;
   logic [2:0]  top_byte;
   logic [6:0]  bit_len;
   logic [5:0]  enc_len;
   logic [5:0]  len_out;
   logic [63:0] res_out;
   logic [6:0]  head;

   assign l3_ready   = !rsp_valid_ff || rsp_tready;
   assign l2_ready   = !l2_valid_ff || l3_ready;
   assign l1_ready   = !l1_valid_ff || l2_ready;
   assign s0_ready   = !s0_valid_ff || chain_ready[0];
   assign req_tready = s0_ready;

   always_comb begin
      s0_item_in.action        = req_tuser[0];
      s0_item_in.with_hundreds = req_tuser[1];
      s0_item_in.length        = req_tdata[72:67];
      s0_item_in.ovf           = 1'b0;
      if (req_tuser[0] == devc_pkg::ACT_DECODE) begin
         s0_item_in.val      = req_tdata[63:0] & ({64{1'b1}} >> (6'd63 - req_tdata[72:67]));
         s0_item_in.hundreds = req_tuser[1] ? req_tdata[66:64] : 3'd0;
      end else begin
         s0_item_in.val      = req_tdata[63:0];
         s0_item_in.hundreds = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         l1_valid_ff  <= 1'b0;
         l2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) s0_valid_ff  <= req_tvalid;
         if (l1_ready) l1_valid_ff  <= chain_valid[SLOTS];
         if (l2_ready) l2_valid_ff  <= l1_valid_ff;
         if (l3_ready) rsp_valid_ff <= l2_valid_ff;
      end
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_item[0]  = s0_item_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      devc_hundred_slot #(
         .SLOT         (i),
         .MAX_HUNDREDS (MAX_HUNDREDS)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   assign chain_ready[SLOTS] = l1_ready;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         l2_bnz_in[b]  = |l1_dec_ff[8*b +: 8];
         l2_bpos_in[b] = 3'd0;
         for (int j = 0; j < 8; j++) begin
            if (l1_dec_ff[8*b + j]) l2_bpos_in[b] = 3'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) s0_item_ff <= s0_item_in;
      if (l1_ready) begin
         l1_item_ff  <= chain_item[SLOTS];
         l1_dec_ff   <= chain_item[SLOTS].val - 64'd1;
         l1_small_ff <= (chain_item[SLOTS].val[63:1] == 63'd0);
      end
      if (l2_ready) begin
         l2_item_ff  <= l1_item_ff;
         l2_small_ff <= l1_small_ff;
         l2_bnz_ff   <= l2_bnz_in;
         l2_bpos_ff  <= l2_bpos_in;
      end
      if (l3_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ovf_ff  <= l2_item_ff.ovf;
      end
   end

   always_comb begin
      top_byte = 3'd0;
      for (int b = 0; b < 8; b++) begin
         if (l2_bnz_ff[b]) top_byte = 3'(b);
      end
      bit_len = {1'b0, top_byte, l2_bpos_ff[top_byte]} + 7'd1;
      if (l2_small_ff) enc_len = 6'd0;
      else if (bit_len[6]) enc_len = 6'd63;
      else enc_len = bit_len[5:0];
      len_out = (l2_item_ff.action == devc_pkg::ACT_ENCODE) ? enc_len : l2_item_ff.length;
      res_out = l2_item_ff.ovf ? 64'd0 : l2_item_ff.val;
      head    = (l2_item_ff.with_hundreds ? devc_pkg::HUNDREDS_HEAD : 7'd0)
                + devc_pkg::LENGTH_HEAD;
      rsp_data_in = {head + {1'b0, len_out} + 7'd1, len_out, l2_item_ff.hundreds, res_out};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   a_ovf_needs_hundreds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[66:64] != 3'd0)
      else $error("overflow reported with no hundreds applied");

   a_strip_bounded: assert property (@(posedge clock) disable iff (reset)
      chain_valid[SLOTS] && chain_item[SLOTS].action == devc_pkg::ACT_ENCODE
      |-> chain_item[SLOTS].hundreds <= 3'(MAX_HUNDREDS) && !chain_item[SLOTS].ovf)
      else $error("encode stripped too many hundreds or flagged overflow");

   a_no_strip_without_option: assert property (@(posedge clock) disable iff (reset)
      chain_valid[SLOTS] && !chain_item[SLOTS].with_hundreds
      |-> chain_item[SLOTS].hundreds == 3'd0)
      else $error("hundreds count set without the hundreds option");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for decimal_exponent_varint_codec_top: drives encode and decode
// items with random gaps and stalls, predicts every result item and compares it field by field.
// Depends on devc_pkg and the codec RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS    = devc_pkg::VALUE_BITS;
   localparam int HUNDREDS_BITS = devc_pkg::HUNDREDS_BITS;
   localparam int LENGTH_BITS   = devc_pkg::LENGTH_BITS;
   localparam int TOTAL_BITS    = devc_pkg::TOTAL_BITS;
   localparam logic ACT_ENCODE  = devc_pkg::ACT_ENCODE;
   localparam logic ACT_DECODE  = devc_pkg::ACT_DECODE;
   localparam logic [TOTAL_BITS-1:0] HUNDREDS_HEAD = devc_pkg::HUNDREDS_HEAD;
   localparam logic [TOTAL_BITS-1:0] LENGTH_HEAD   = devc_pkg::LENGTH_HEAD;

   localparam int MAX_STRIP = 7;
   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_CHUNKS = 7;
   localparam int CHUNK_ITEMS = 150;
   localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] MUL_SAFE_MAX = ALL_ONES / 64'd100;

   typedef struct packed {
      logic                     action;
      logic                     with_hundreds;
      logic [VALUE_BITS-1:0]    number;
      logic [HUNDREDS_BITS-1:0] hundreds;
      logic [LENGTH_BITS-1:0]   length;
   } request_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]    number;
      logic [HUNDREDS_BITS-1:0] hundreds;
      logic [LENGTH_BITS-1:0]   length;
      logic [TOTAL_BITS-1:0]    total;
      logic                     overflow;
   } result_type;

   class codec_checker;
      result_type pending_codes[$];
      int         failures = 0;
      int         encodes = 0;
      int         decodes = 0;
      int         overflows = 0;

      function automatic result_type code_number(request_type r);
         result_type            o;
         logic [VALUE_BITS-1:0] v;
         logic [VALUE_BITS:0]   p;
         int                    c;
         int                    hc;
         int                    bits;
         o = '0;
         hc = 0;
         if (r.action == ACT_ENCODE) begin
            v = r.number;
            if (r.with_hundreds) begin
               while (hc < MAX_STRIP && (v % 64'd100) == 0) begin
                  v = v / 64'd100;
                  hc++;
               end
            end
            c = 1;
            p = 1;
            while (c < VALUE_BITS && p < {1'b0, v}) begin
               c++;
               p = p << 1;
            end
            o.number = v;
            o.length = LENGTH_BITS'(c - 1);
         end else begin
            bits = int'(r.length) + 1;
            v = (bits >= VALUE_BITS) ? r.number : (r.number & ((64'd1 << bits) - 64'd1));
            hc = r.with_hundreds ? int'(r.hundreds) : 0;
            for (int i = 0; i < hc && !o.overflow; i++) begin
               if (v > MUL_SAFE_MAX) o.overflow = 1'b1;
               else v = v * 64'd100;
            end
            o.number = o.overflow ? '0 : v;
            o.length = r.length;
         end
         o.hundreds = HUNDREDS_BITS'(hc);
         o.total = (r.with_hundreds ? HUNDREDS_HEAD : 7'd0) + LENGTH_HEAD
                   + TOTAL_BITS'(o.length) + 7'd1;
         return o;
      endfunction

      function void note_request(request_type r);
         result_type e;
         e = code_number(r);
         if (r.action == ACT_ENCODE) encodes++;
         else decodes++;
         if (e.overflow) overflows++;
         pending_codes = {pending_codes, e};
      endfunction

      function void check_result(result_type got);
         result_type e;
         if (pending_codes.size() == 0) begin
            $error("result item with none expected: number %h", got.number);
            failures++;
            return;
         end
         e = pending_codes.pop_front();
         if (got.number !== e.number) begin
            $error("result_number: expected %h, got %h", e.number, got.number);
            failures++;
         end
         if (got.hundreds !== e.hundreds) begin
            $error("hundreds_out: expected %0d, got %0d", e.hundreds, got.hundreds);
            failures++;
         end
         if (got.length !== e.length) begin
            $error("length_out: expected %0d, got %0d", e.length, got.length);
            failures++;
         end
         if (got.total !== e.total) begin
            $error("total_bits: expected %0d, got %0d", e.total, got.total);
            failures++;
         end
         if (got.overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, got.overflow);
            failures++;
         end
      endfunction

      function int pending();
         return pending_codes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   codec_checker codes;
   bit           idle_on;
   int           quiet_cycles;

   decimal_exponent_varint_codec_top #(
      .MAX_HUNDREDS(MAX_STRIP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [VALUE_BITS-1:0] hundred_power(int k);
      logic [VALUE_BITS-1:0] v;
      v = 64'd1;
      for (int i = 0; i < k; i++) v = v * 64'd100;
      return v;
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic request_type make_req(logic act, logic wh, logic [VALUE_BITS-1:0] num,
                                            int hin, int len);
      request_type r;
      r.action = act;
      r.with_hundreds = wh;
      r.number = num;
      r.hundreds = HUNDREDS_BITS'(hin);
      r.length = LENGTH_BITS'(len);
      return r;
   endfunction

   function automatic request_type draw_request();
      request_type           r;
      logic [VALUE_BITS-1:0] v;
      int                    k;
      r = make_req(($urandom_range(0, 1) == 1) ? ACT_DECODE : ACT_ENCODE,
                   $urandom_range(0, 3) != 0, random_word(), $urandom_range(0, 7),
                   $urandom_range(0, 63));
      if (r.action == ACT_ENCODE) begin
         case ($urandom_range(0, 5))
            0: v = random_word();
            1: v = 64'($urandom_range(0, 1000));
            2: v = 64'($urandom_range(1, 1 << 20)) * hundred_power($urandom_range(0, 9));
            3: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
            4: v = ($urandom_range(0, 1) == 1) ? ALL_ONES : '0;
            default: v = random_word() >> $urandom_range(0, 63);
         endcase
         r.number = v;
      end else begin
         case ($urandom_range(0, 3))
            0: r.length = LENGTH_BITS'($urandom_range(0, 20));
            1: begin
               k = $urandom_range(1, 7);
               r.hundreds = HUNDREDS_BITS'(k);
               r.length = LENGTH_BITS'(VALUE_BITS - 1);
               r.number = ALL_ONES / hundred_power(k) + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic send_item(request_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, r.length, r.hundreds, r.number};
      req_tuser <= {r.with_hundreds, r.action};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (codes.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      request_type list[$];
      list = {list, make_req(ACT_ENCODE, 1'b1, '0, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b0, '0, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b0, 64'd1, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b0, 64'd2, 7, 63)};
      list = {list, make_req(ACT_ENCODE, 1'b1, 64'd3, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b1, ALL_ONES, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b0, 64'd100, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b1, hundred_power(7), 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b1, hundred_power(9), 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b1, 64'd1 << 63, 0, 0)};
      list = {list, make_req(ACT_ENCODE, 1'b0, (64'd1 << 63) + 64'd1, 0, 0)};
      list = {list, make_req(ACT_DECODE, 1'b0, ALL_ONES, 0, 63)};
      list = {list, make_req(ACT_DECODE, 1'b0, ALL_ONES, 7, 0)};
      list = {list, make_req(ACT_DECODE, 1'b1, ALL_ONES, 0, 0)};
      list = {list, make_req(ACT_DECODE, 1'b1, 64'd1, 7, 5)};
      list = {list, make_req(ACT_DECODE, 1'b1, ALL_ONES, 1, 63)};
      list = {list, make_req(ACT_DECODE, 1'b1, MUL_SAFE_MAX, 1, 63)};
      list = {list, make_req(ACT_DECODE, 1'b1, MUL_SAFE_MAX + 64'd1, 1, 63)};
      list = {list, make_req(ACT_DECODE, 1'b1, 64'd1 << 40, 7, 63)};
      list = {list, make_req(ACT_DECODE, 1'b1, ALL_ONES, 7, 10)};
      list = {list, make_req(ACT_DECODE, 1'b1, ALL_ONES / hundred_power(7), 7, 63)};
      foreach (list[i]) send_item(list[i]);
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         codes.note_request({req_tuser[0], req_tuser[1], req_tdata[63:0], req_tdata[66:64],
                             req_tdata[72:67]});
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         codes.check_result({rsp_tdata[63:0], rsp_tdata[66:64], rsp_tdata[72:67],
                             rsp_tdata[79:73], rsp_tuser});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      codes = new();
      idle_on = 1'b1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         idle_on = (chunk % 3) != 1;
         if (chunk == 3) hold_until_drained();
         for (int n = 0; n < CHUNK_ITEMS; n++) send_item(draw_request());
      end
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d encode and %0d decode items, %0d of them with overflow,",
               codes.encodes, codes.decodes, codes.overflows);
      $display("under random and no source gaps and sink stalls, with one full drain.");
      if (codes.failures == 0 && codes.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
